[rtl/pwt_pkg.sv]
`timescale 1ns / 1ps
package pwt_pkg;
    localparam int DataBits = 32;
    localparam int FieldBits = 32;

    typedef enum logic [1:0] {
        VERDICT_COMPOSITE = 2'd0,
        VERDICT_PRIME     = 2'd1,
        VERDICT_INVALID   = 2'd2
    } verdict_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_POW_SQ,
        ST_POW_MUL,
        ST_POW_NEXT,
        ST_MR_TEST,
        ST_MR_SQ,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic shift_u;
        logic mul_start;
        logic mul_sel_base;
        logic exp_step;
        logic sq_x;
        logic mr_step;
    } pwt_cmd_t;

    typedef struct packed {
        logic mode;
        logic is_two;
        logic invalid;
        logic u_even;
        logic mul_busy;
        logic exp_bit;
        logic exp_last;
        logic acc_one;
        logic acc_nm1;
        logic t_zero;
    } pwt_status_t;
endpackage

[rtl/pwt_if.sv]
`timescale 1ns / 1ps
interface pwt_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/pwt_mulmod.sv]
`timescale 1ns / 1ps
module pwt_mulmod
    import pwt_pkg::*;
#(
    parameter int DATA_BITS = DataBits
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DATA_BITS-1:0] x,
    input  logic [DATA_BITS-1:0] y,
    input  logic [DATA_BITS-1:0] m,
    output logic                 busy,
    output logic [DATA_BITS-1:0] result
);
    localparam int CntBits = $clog2(DATA_BITS);

    logic [DATA_BITS-1:0] acc_reg, acc_next;
    logic [DATA_BITS-1:0] y_reg, y_next;
    logic [CntBits-1:0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DATA_BITS:0]   dbl, dsub, add, asub;
    logic [DATA_BITS-1:0] d;

    // double then conditionally add x, both reduced mod m
    always_comb
    begin
        dbl  = {acc_reg, 1'b0};
        dsub = dbl - {1'b0, m};
        d    = dsub[DATA_BITS] ? dbl[DATA_BITS-1:0] : dsub[DATA_BITS-1:0];
        add  = {1'b0, d} + {1'b0, x};
        asub = add - {1'b0, m};
        acc_next = acc_reg;
        y_next   = y_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            y_next    = y;
            cnt_next  = CntBits'(DATA_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg[DATA_BITS-1])
                acc_next = asub[DATA_BITS] ? add[DATA_BITS-1:0] : asub[DATA_BITS-1:0];
            else
                acc_next = d;
            y_next = {y_reg[DATA_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("mulmod not busy after start");
    a_end_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy_reg) && !$past(start)) |-> ($past(cnt_reg) == '0))
        else $error("mulmod ended early");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("mulmod restarted while busy");
`endif
endmodule

[rtl/pwt_datapath.sv]
`timescale 1ns / 1ps
module pwt_datapath
    import pwt_pkg::*;
#(
    parameter int DATA_BITS = DataBits
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwt_cmd_t             cmd,
    input  logic                 mode,
    input  logic [FieldBits-1:0] candidate,
    input  logic [FieldBits-1:0] witness_base,
    output pwt_status_t          status
);
    localparam int CntBits = $clog2(DATA_BITS + 1);

    logic [DATA_BITS-1:0] n_reg, a_reg, u_reg, acc_reg;
    logic [DATA_BITS-1:0] n_in, a_in, nm1, mul_y, mul_res;
    logic [CntBits-1:0]   t_reg, bit_reg;
    logic                 mode_reg;
    logic                 mul_busy;

    assign n_in = DATA_BITS'(candidate);
    assign a_in = DATA_BITS'(witness_base);
    assign nm1  = n_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= n_in;
            a_reg    <= a_in;
            u_reg    <= n_in - 1'b1;
            mode_reg <= mode;
            t_reg    <= '0;
            acc_reg  <= {{(DATA_BITS-1){1'b0}}, 1'b1};
            bit_reg  <= CntBits'(DATA_BITS - 1);
        end
        else
        begin
            if (cmd.shift_u)
            begin
                u_reg <= u_reg >> 1;
                t_reg <= t_reg + 1'b1;
            end
            if (cmd.exp_step)
                bit_reg <= bit_reg - 1'b1;
            if (cmd.mr_step)
                t_reg <= t_reg - 1'b1;
            if (cmd.sq_x)
                acc_reg <= mul_res;
        end
    end

    assign mul_y = cmd.mul_sel_base ? a_reg : acc_reg;

    pwt_mulmod #(.DATA_BITS(DATA_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .x      (acc_reg),
        .y      (mul_y),
        .m      (n_reg),
        .busy   (mul_busy),
        .result (mul_res)
    );

    always_comb
    begin
        status.mode     = mode_reg;
        status.is_two   = (n_reg == DATA_BITS'(2));
        status.invalid  = (n_reg < DATA_BITS'(3)) || (a_reg < DATA_BITS'(2)) || (a_reg > nm1);
        status.u_even   = mode_reg && !u_reg[0];
        status.mul_busy = mul_busy;
        status.exp_bit  = u_reg[bit_reg[$clog2(DATA_BITS)-1:0]];
        status.exp_last = (bit_reg == '0);
        status.acc_one  = (acc_reg == DATA_BITS'(1));
        status.acc_nm1  = (acc_reg == nm1);
        status.t_zero   = (t_reg == '0);
    end
endmodule

[rtl/pwt_ctrl.sv]
`timescale 1ns / 1ps
module pwt_ctrl
    import pwt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    input  pwt_status_t status,
    output pwt_cmd_t    cmd
);
    ctrl_state_t state_reg, state_next;
    verdict_t    verdict_reg, verdict_next;
    logic        wait_reg, wait_next;

    // wait_reg: a multiply was launched and its result is pending
    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        wait_next    = wait_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.is_two)
                begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = ST_DONE;
                end
                else if (status.invalid)
                begin
                    verdict_next = VERDICT_INVALID;
                    state_next   = ST_DONE;
                end
                else
                    state_next = ST_SPLIT;
            end
            ST_SPLIT:
                if (!status.u_even)
                begin
                    state_next = ST_POW_SQ;
                    wait_next  = 1'b0;
                end
            ST_POW_SQ:
                if (!wait_reg)
                    wait_next = 1'b1;
                else if (!status.mul_busy)
                begin
                    wait_next  = 1'b0;
                    state_next = status.exp_bit ? ST_POW_MUL : ST_POW_NEXT;
                end
            ST_POW_MUL:
                if (!wait_reg)
                    wait_next = 1'b1;
                else if (!status.mul_busy)
                begin
                    wait_next  = 1'b0;
                    state_next = ST_POW_NEXT;
                end
            ST_POW_NEXT:
                if (!status.exp_last)
                    state_next = ST_POW_SQ;
                else if (!status.mode)
                begin
                    verdict_next = status.acc_one ? VERDICT_PRIME : VERDICT_COMPOSITE;
                    state_next   = ST_DONE;
                end
                else if (status.acc_one)
                begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = ST_DONE;
                end
                else
                    state_next = ST_MR_TEST;
            ST_MR_TEST:
                if (status.t_zero)
                begin
                    verdict_next = VERDICT_COMPOSITE;
                    state_next   = ST_DONE;
                end
                else if (status.acc_nm1)
                begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = ST_DONE;
                end
                else
                    state_next = ST_MR_SQ;
            ST_MR_SQ:
                if (!wait_reg)
                    wait_next = 1'b1;
                else if (!status.mul_busy)
                begin
                    wait_next  = 1'b0;
                    state_next = ST_MR_TEST;
                end
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);
        verdict   = verdict_reg;
        case (state_reg)
            ST_IDLE:
                cmd.load = in_valid;
            ST_SPLIT:
                cmd.shift_u = status.u_even;
            ST_POW_SQ:
            begin
                cmd.mul_start = !wait_reg;
                cmd.sq_x      = wait_reg && !status.mul_busy;
            end
            ST_POW_MUL:
            begin
                cmd.mul_start    = !wait_reg;
                cmd.mul_sel_base = 1'b1;
                cmd.sq_x         = wait_reg && !status.mul_busy;
            end
            ST_POW_NEXT:
                cmd.exp_step = !status.exp_last;
            ST_MR_SQ:
            begin
                cmd.mul_start = !wait_reg;
                cmd.sq_x      = wait_reg && !status.mul_busy;
                cmd.mr_step   = wait_reg && !status.mul_busy;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= VERDICT_COMPOSITE;
            wait_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            wait_reg    <= wait_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(verdict)))
        else $error("result dropped");
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while result pending");
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict != 2'd3)) else $error("bad verdict");
`endif
endmodule

[rtl/primality_witness_test.sv]
`timescale 1ns / 1ps
// channel   dir  payload
// req       in   mode[0], candidate[32:1], witness_base[64:33]
// rsp       out  verdict[1:0]
// one request at a time; up to 2*DATA_BITS modular multiplies for the power, plus
// one squaring per strong-test round, each in the shared bit-serial multiplier,
// with a step state per exponent bit and per squaring round.
// invalid or two candidates are answered from the check state, with no multiply.
// rst_n asynchronous; the result holds until taken, req stalls meanwhile.
module primality_witness_test
    import pwt_pkg::*;
#(
    parameter int DATA_BITS = DataBits
)
(
    input  logic clk,
    input  logic rst_n,
    pwt_if.sink   req,
    pwt_if.source rsp
);
    pwt_cmd_t    cmd;
    pwt_status_t status;

    pwt_datapath #(.DATA_BITS(DATA_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (req.data[0]),
        .candidate    (req.data[FieldBits:1]),
        .witness_base (req.data[2*FieldBits:FieldBits+1]),
        .status       (status)
    );

    pwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .verdict   (rsp.data[1:0]),
        .status    (status),
        .cmd       (cmd)
    );
endmodule

[sim/primality_witness_checker.sv]
`timescale 1ns / 1ps
module primality_witness_checker
    import pwt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [64:0] req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  rsp_data,
    output int          fail_count,
    output int          pending_count,
    output int          verdict_seen [3]
);
    verdict_t expected_verdicts [$];

    // shift-and-add modular product, operands below m
    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        for (int b = 63; b >= 0; b--)
        begin
            acc = (acc >= m - acc) ? acc - (m - acc) : acc + acc;
            if (y[b])
                acc = (acc >= m - x) ? acc - (m - x) : acc + x;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 1;
        for (int b = 63; b >= 0; b--)
        begin
            acc = mod_mul(acc, acc, m);
            if (e[b])
                acc = mod_mul(acc, base, m);
        end
        return acc;
    endfunction

    function automatic verdict_t predict_verdict(logic mode, logic [31:0] cand, logic [31:0] base);
        logic [63:0] n, a, nm1, u, x;
        int t;
        n = cand;
        a = base;
        if (n == 2)
            return VERDICT_PRIME;
        if (n < 3)
            return VERDICT_INVALID;
        nm1 = n - 1;
        if (a < 2 || a > nm1)
            return VERDICT_INVALID;
        if (!mode)
            return (mod_pow(a, nm1, n) == 1) ? VERDICT_PRIME : VERDICT_COMPOSITE;
        u = nm1;
        t = 0;
        while (!u[0])
        begin
            u = u >> 1;
            t++;
        end
        x = mod_pow(a, u, n);
        if (x == 1)
            return VERDICT_PRIME;
        for (int j = 0; j < t; j++)
        begin
            if (x == nm1)
                return VERDICT_PRIME;
            x = mod_mul(x, x, n);
        end
        return VERDICT_COMPOSITE;
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        for (int i = 0; i < 3; i++)
            verdict_seen[i] = 0;
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && req_valid && req_ready)
            expected_verdicts.push_back(predict_verdict(req_data[0], req_data[32:1],
                                                        req_data[64:33]));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict: expected none, actual %0d", $time, rsp_data);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (rsp_data !== want)
                begin
                    $display("%0t: verdict mismatch: expected %0d, actual %0d",
                             $time, want, rsp_data);
                    fail_count++;
                end
                if (rsp_data < 3)
                    verdict_seen[rsp_data]++;
            end
        end
        pending_count = expected_verdicts.size();
    end
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import pwt_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count, pending_count;
    int   verdict_seen [3];
    logic hold_rsp = 0;
    int   request_count = 0;

    pwt_if #(.W(65)) req ();
    pwt_if #(.W(2))  rsp ();

    primality_witness_test uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    primality_witness_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
        .fail_count(fail_count), .pending_count(pending_count), .verdict_seen(verdict_seen)
    );

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.data = '0;
        rsp.ready = 0;
    end

    // receiver stall pattern, with a long hold-off when asked
    initial
    begin
        @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_request(logic mode, logic [31:0] cand, logic [31:0] base);
        req.valid <= 1'b1;
        req.data <= {base, cand, mode};
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        request_count++;
        @(negedge clk);
    endtask

    task automatic idle_gap();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 12))
            @(negedge clk);
    endtask

    function automatic logic [31:0] random_candidate();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(3, 300);
            2: return $urandom | 32'h8000_0001;
            default: return $urandom_range(3, 65535) | 1;
        endcase
    endfunction

    function automatic logic [31:0] random_base(logic [31:0] cand);
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        if (cand < 4)
            return 2;
        case ($urandom_range(0, 3))
            0: return 2;
            1: return cand - 1;
            default: return 2 + ($urandom % (cand - 2));
        endcase
    endfunction

    initial
    begin
        logic [31:0] cand;
        int          burst;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2)
            @(negedge clk);

        for (int m = 0; m < 2; m++)
        begin
            send_request(1'(m), 0, 5);
            send_request(1'(m), 1, 0);
            send_request(1'(m), 2, 32'hFFFF_FFFF);
            send_request(1'(m), 3, 2);
            send_request(1'(m), 7, 1);
            send_request(1'(m), 7, 7);
            send_request(1'(m), 561, 2);            // carmichael, fools fermat
            send_request(1'(m), 2047, 2);           // strong pseudoprime to base 2
            send_request(1'(m), 100, 3);            // even candidate
            send_request(1'(m), 32'hFFFF_FFFB, 32'hFFFF_FFFA);
            send_request(1'(m), 32'hFFFF_FFFF, 32'hAAAA_5555);
            send_request(1'(m), 32'hFFFF_FFFE, 32'h5555_AAAA);
        end
        idle_gap();

        // long receiver hold-off while requests keep coming
        hold_rsp = 1;
        fork
            begin
                repeat (3000)
                    @(negedge clk);
                hold_rsp = 0;
            end
            for (int i = 0; i < 4; i++)
                send_request(1'($urandom), 97, $urandom_range(2, 96));
        join
        req.valid <= 1'b0;

        // sender waits for the block to drain
        while (pending_count != 0)
            @(negedge clk);

        while (request_count < 290)
        begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++)
            begin
                cand = random_candidate();
                send_request(1'($urandom), cand, random_base(cand));
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap();
        end
        req.valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (50)
            @(negedge clk);
        $display("covered %0d requests in both modes: %0d composite, %0d prime, %0d invalid",
                 request_count, verdict_seen[0], verdict_seen[1], verdict_seen[2]);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

[primality_witness_test.f]
rtl/pwt_pkg.sv
rtl/pwt_if.sv
rtl/pwt_mulmod.sv
rtl/pwt_datapath.sv
rtl/pwt_ctrl.sv
rtl/primality_witness_test.sv
sim/primality_witness_checker.sv
sim/testbench.sv
